// ----- design/srsma_pkg.sv -----
// ----------------------------------------------------------------------------
// srsma_pkg
// shared types and constants of the sparse row scaled merge-add block
// ----------------------------------------------------------------------------
package srsma_pkg;

  localparam int DefaultMaxRowEntries = 32;
  localparam int DefaultColumnBits    = 16;

  localparam int ColumnFieldW = 16;
  localparam int ValueW       = 32;
  localparam int OpcodeW      = 2;
  localparam int ProductW     = 2 * ValueW;

  localparam logic signed [ValueW-1:0] ScaleReset = 32'sh0001_0000;
  localparam logic signed [ValueW-1:0] ValueMax   = 32'sh7FFF_FFFF;
  localparam logic signed [ValueW-1:0] ValueMin   = 32'sh8000_0000;

  typedef enum logic [OpcodeW-1:0] {
    OP_LOAD_X  = 2'd0,
    OP_LOAD_Y  = 2'd1,
    OP_END_ROW = 2'd2
  } opcode_e;

endpackage

// ----- design/srsma_store.sv -----
// ----------------------------------------------------------------------------
// srsma_store
// entry buffer of one list: one write port, one read port, registered read
// ----------------------------------------------------------------------------
module srsma_store
  import srsma_pkg::*;
#(
  parameter int Depth = DefaultMaxRowEntries,
  parameter int Width = ColumnFieldW + ValueW
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // out-of-range read addresses only occur when the read is not used
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sparse_row_scaled_merge_add.sv -----
// ----------------------------------------------------------------------------
// sparse_row_scaled_merge_add
// one row of a*X + Y for compressed-row sparse matrices
// ----------------------------------------------------------------------------
// Load requests (tuser 0 for X, 1 for Y) store a column and a Q16.16 value
// into the X or Y buffer, one request per cycle; a load into a full buffer is
// dropped and sets the row's overflow flag. An end-of-row request (tuser 2)
// merges both column-sorted buffers and streams their union in column order:
// a*x+y on matching columns, a*x for X-only and y for Y-only entries, each
// saturated to 32 bits. With a zero scale factor only Y entries are emitted.
// A row without entries gives a single result with row_empty and tlast set.
// Each merge result passes through three steps: a read of the synchronous
// buffers, the 32x32 multiply, and the add with saturation, which waits
// while the output does not drain. No new request is taken while a row is
// merging. The user must write the scale factor through cfg_we_i/cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sparse_row_scaled_merge_add
  import srsma_pkg::*;
#(
  parameter int MAX_ROW_ENTRIES = DefaultMaxRowEntries,
  parameter int COLUMN_BITS     = DefaultColumnBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: scale factor a, signed Q16.16
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // [15:0] column, [47:16] value
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] opcode
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // [15:0] out_column, [47:16] out_value
  output logic        m_axis_tlast_o,  // last
  output logic [2:0]  m_axis_tuser_o   // [0] row_empty, [1] overflow, [2] saturated
);

  localparam int IdxW   = (MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1;
  localparam int CntW   = $clog2(MAX_ROW_ENTRIES + 1);
  localparam int ColW   = (COLUMN_BITS < ColumnFieldW) ? COLUMN_BITS : ColumnFieldW;
  localparam int EntryW = ValueW + ColW;
  localparam int SumW   = ProductW - 16 + 1;

  localparam logic [CntW-1:0] CntFull = CntW'(MAX_ROW_ENTRIES);

  // merge sequencer states
  localparam logic [2:0] S_LOAD  = 3'd0;  // taking loads, waiting for end of row
  localparam logic [2:0] S_READ  = 3'd1;  // buffer read in flight
  localparam logic [2:0] S_MUL   = 3'd2;  // pick heads, multiply
  localparam logic [2:0] S_ADD   = 3'd3;  // add, saturate, hand to output
  localparam logic [2:0] S_EMPTY = 3'd4;  // single empty-row result

  logic [2:0] state_q, state_d;

  logic signed [ValueW-1:0] scale_q, scale_d;

  logic [CntW-1:0] x_cnt_q, x_cnt_d;
  logic [CntW-1:0] y_cnt_q, y_cnt_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] nx_q, nx_d;  // x entries taking part in the merge
  logic [CntW-1:0] ny_q, ny_d;
  logic [CntW-1:0] i_q, i_d;    // merge heads
  logic [CntW-1:0] j_q, j_d;

  // input request decode
  logic              in_acc;
  logic [ColW-1:0]   in_col;
  logic [ValueW-1:0] in_val;
  logic              x_we, y_we;
  logic [EntryW-1:0] x_rdata, y_rdata;

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_col          = s_axis_tdata_i[ColW-1:0];
  assign in_val          = s_axis_tdata_i[16 +: ValueW];

  srsma_store #(
    .Depth (MAX_ROW_ENTRIES),
    .Width (EntryW)
  ) u_x_store (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (x_cnt_q[IdxW-1:0]),
    .wdata_i ({in_val, in_col}),
    .raddr_i (i_q[IdxW-1:0]),
    .rdata_o (x_rdata)
  );

  srsma_store #(
    .Depth (MAX_ROW_ENTRIES),
    .Width (EntryW)
  ) u_y_store (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (y_cnt_q[IdxW-1:0]),
    .wdata_i ({in_val, in_col}),
    .raddr_i (j_q[IdxW-1:0]),
    .rdata_o (y_rdata)
  );

  // head compare on the registered buffer reads
  logic [ColW-1:0]          cx, cy;
  logic signed [ValueW-1:0] xv, yv;
  logic                     hx, hy, take_x, take_y;
  logic [CntW-1:0]          i_next, j_next;
  logic signed [ProductW-1:0] product;

  assign cx      = x_rdata[ColW-1:0];
  assign xv      = x_rdata[ColW +: ValueW];
  assign cy      = y_rdata[ColW-1:0];
  assign yv      = y_rdata[ColW +: ValueW];
  assign hx      = (i_q < nx_q);
  assign hy      = (j_q < ny_q);
  assign take_x  = hx && (!hy || (cx <= cy));
  assign take_y  = hy && (!hx || (cy <= cx));
  assign i_next  = i_q + CntW'(take_x);
  assign j_next  = j_q + CntW'(take_y);
  assign product = scale_q * xv;

  // multiply stage registers
  logic signed [ProductW-1:0] prod_q, prod_d;
  logic signed [ValueW-1:0]   yadd_q, yadd_d;
  logic [ColW-1:0]            mcol_q, mcol_d;
  logic                       mlast_q, mlast_d;

  // add and saturate: floor(a*x / 2^16) + y
  logic signed [SumW-2:0] scaled;
  logic signed [SumW-1:0] sum;
  logic                   sat;
  logic [ValueW-1:0]      sat_val;

  assign scaled  = prod_q[ProductW-1:16];
  assign sum     = SumW'(scaled) + SumW'(yadd_q);
  assign sat     = !((&sum[SumW-1:ValueW-1]) || !(|sum[SumW-1:ValueW-1]));
  assign sat_val = sat ? (sum[SumW-1] ? ValueMin : ValueMax) : sum[ValueW-1:0];

  // output register
  logic                    out_valid_q, out_valid_d;
  logic                    out_free, out_load;
  logic [ColumnFieldW-1:0] out_col_q, out_col_d;
  logic [ValueW-1:0]       out_val_q, out_val_d;
  logic                    out_last_q, out_last_d;
  logic                    out_empty_q, out_empty_d;
  logic                    out_ovf_q, out_ovf_d;
  logic                    out_sat_q, out_sat_d;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    scale_d     = cfg_we_i ? cfg_wdata_i : scale_q;
    x_cnt_d     = x_cnt_q;
    y_cnt_d     = y_cnt_q;
    ovf_d       = ovf_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    i_d         = i_q;
    j_d         = j_q;
    x_we        = 1'b0;
    y_we        = 1'b0;
    prod_d      = prod_q;
    yadd_d      = yadd_q;
    mcol_d      = mcol_q;
    mlast_d     = mlast_q;
    out_load    = 1'b0;
    out_col_d   = out_col_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_ovf_d   = out_ovf_q;
    out_sat_d   = out_sat_q;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          case (opcode_e'(s_axis_tuser_i))
            OP_LOAD_X: begin
              if (x_cnt_q == CntFull) begin
                ovf_d = 1'b1;
              end else begin
                x_we    = 1'b1;
                x_cnt_d = x_cnt_q + CntW'(1);
              end
            end
            OP_LOAD_Y: begin
              if (y_cnt_q == CntFull) begin
                ovf_d = 1'b1;
              end else begin
                y_we    = 1'b1;
                y_cnt_d = y_cnt_q + CntW'(1);
              end
            end
            OP_END_ROW: begin
              // a zero scale factor drops the X list from the merge
              nx_d = (scale_q != '0) ? x_cnt_q : '0;
              ny_d = y_cnt_q;
              i_d  = '0;
              j_d  = '0;
              if ((nx_d == '0) && (y_cnt_q == '0)) begin
                state_d = S_EMPTY;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              // unused opcode, no effect
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = take_x ? product : '0;
        yadd_d  = take_y ? yv : '0;
        mcol_d  = take_x ? cx : cy;
        mlast_d = (i_next == nx_q) && (j_next == ny_q);
        i_d     = i_next;
        j_d     = j_next;
        state_d = S_ADD;
      end
      S_ADD: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_col_d   = ColumnFieldW'(mcol_q);
          out_val_d   = sat_val;
          out_last_d  = mlast_q;
          out_empty_d = 1'b0;
          out_ovf_d   = ovf_q;
          out_sat_d   = sat;
          if (mlast_q) begin
            x_cnt_d = '0;
            y_cnt_d = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_col_d   = '0;
          out_val_d   = '0;
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
          out_ovf_d   = ovf_q;
          out_sat_d   = 1'b0;
          x_cnt_d     = '0;
          y_cnt_d     = '0;
          ovf_d       = 1'b0;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      scale_q     <= ScaleReset;
      x_cnt_q     <= '0;
      y_cnt_q     <= '0;
      ovf_q       <= 1'b0;
      nx_q        <= '0;
      ny_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scale_q     <= scale_d;
      x_cnt_q     <= x_cnt_d;
      y_cnt_q     <= y_cnt_d;
      ovf_q       <= ovf_d;
      nx_q        <= nx_d;
      ny_q        <= ny_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    yadd_q      <= yadd_d;
    mcol_q      <= mcol_d;
    mlast_q     <= mlast_d;
    out_col_q   <= out_col_d;
    out_val_q   <= out_val_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
    out_sat_q   <= out_sat_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_val_q, out_col_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = {out_sat_q, out_ovf_q, out_empty_q};

  // buffers never count past their depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_cnt_q <= CntFull) && (y_cnt_q <= CntFull))
    else $error("entry count beyond buffer depth");

  // a merge step always has at least one list head left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> ((i_q < nx_q) || (j_q < ny_q)))
    else $error("merge step with both lists exhausted");

  // finishing a row leaves empty buffers and a clear overflow flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ADD) && out_free && mlast_q) |=>
      ((state_q == S_LOAD) && (x_cnt_q == '0) && (y_cnt_q == '0) && !ovf_q))
    else $error("row end did not clear buffers");

  // an empty-row result is always the last of its row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> m_axis_tlast_o)
    else $error("empty-row result without last");

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sparse row scaled merge-add block
// ----------------------------------------------------------------------------
// A short table of directed requests covers the reset state, value extremes,
// saturation both ways, the unused opcode and an unsorted row. Random rows
// follow in phases with different scale factors and idle patterns. Every
// accepted request runs through a row merge predictor kept in the bench; each
// result leaving the block is checked against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;
  import srsma_pkg::*;

  localparam int MaxEntries   = 32;
  localparam int SettleCycles = 8;
  localparam int DrainCycles  = 16;
  localparam int PhaseItems   = 4;
  localparam int NumPhases    = 8;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [15:0] column;
    logic [31:0] value;
    logic        last;
    logic        empty;
    logic        overflow;
    logic        saturated;
  } row_result_t;

  // one line of the directed table; want only counts when typed is set
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] column;
    logic [31:0] value;
    logic        typed;
    row_result_t want;
  } directed_req_t;

  typedef logic [15:0] column_q_t[$];

  localparam row_result_t NoResult = '0;
  localparam row_result_t EmptyRow = '{column: 16'h0, value: 32'h0, last: 1'b1,
                                       empty: 1'b1, overflow: 1'b0,
                                       saturated: 1'b0};

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        cfg_we  = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [47:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        m_ready = 1'b0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [2:0]  m_axis_tuser_o;

  // predictor state: the two row buffers, counts, overflow and scale a
  logic [15:0]        x_cols [MaxEntries];
  logic signed [31:0] x_vals [MaxEntries];
  logic [15:0]        y_cols [MaxEntries];
  logic signed [31:0] y_vals [MaxEntries];
  int                 x_count;
  int                 y_count;
  bit                 row_overflow;
  logic signed [31:0] scale_a;

  row_result_t   merged_row[$];       // results of the last request
  row_result_t   pending_results[$];  // predicted, not yet seen
  directed_req_t directed_reqs[$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  sparse_row_scaled_merge_add dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // a*x in Q16.16, floor of the exact product
  function automatic logic signed [63:0] scale_x(logic signed [31:0] x);
    logic signed [63:0] a_wide;
    logic signed [63:0] x_wide;
    a_wide = scale_a;
    x_wide = x;
    return (a_wide * x_wide) >>> 16;
  endfunction

  function automatic void add_merged(logic [15:0] col, logic signed [63:0] sum,
                                     bit is_empty);
    row_result_t r;
    r = '0;
    r.column   = col;
    r.empty    = is_empty;
    r.overflow = row_overflow;
    if (sum > 64'sh7FFF_FFFF) begin
      r.value     = ValueMax;
      r.saturated = 1'b1;
    end else if (sum < -64'sh8000_0000) begin
      r.value     = ValueMin;
      r.saturated = 1'b1;
    end else begin
      r.value = sum[31:0];
    end
    merged_row.push_back(r);
  endfunction

  // update buffers on a load, merge and clear them on end of row
  function automatic void apply_request(logic [1:0] op, logic [15:0] col,
                                        logic [31:0] val);
    int          i;
    int          j;
    int          nx;
    row_result_t tail;
    merged_row.delete();
    if (op == OP_LOAD_X) begin
      if (x_count >= MaxEntries) begin
        row_overflow = 1'b1;
      end else begin
        x_cols[x_count] = col;
        x_vals[x_count] = val;
        x_count++;
      end
      return;
    end
    if (op == OP_LOAD_Y) begin
      if (y_count >= MaxEntries) begin
        row_overflow = 1'b1;
      end else begin
        y_cols[y_count] = col;
        y_vals[y_count] = val;
        y_count++;
      end
      return;
    end
    if (op != OP_END_ROW) return;

    // zero scale drops the x list entirely
    nx = (scale_a != 0) ? x_count : 0;
    i = 0;
    j = 0;
    while (i < nx || j < y_count) begin
      if (i < nx && (j >= y_count || x_cols[i] < y_cols[j])) begin
        add_merged(x_cols[i], scale_x(x_vals[i]), 1'b0);
        i++;
      end else if (i >= nx || y_cols[j] < x_cols[i]) begin
        add_merged(y_cols[j], 64'(y_vals[j]), 1'b0);
        j++;
      end else begin
        add_merged(x_cols[i], scale_x(x_vals[i]) + 64'(y_vals[j]), 1'b0);
        i++;
        j++;
      end
    end
    if (merged_row.size() == 0) add_merged(16'h0, 64'sd0, 1'b1);
    tail = merged_row.pop_back();
    tail.last = 1'b1;
    merged_row.push_back(tail);
    x_count      = 0;
    y_count      = 0;
    row_overflow = 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // hold one request until the block takes it, with random idle before it
  task automatic send_request(logic [1:0] op, logic [15:0] col, logic [31:0] val);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {val, col};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (op != OpUnused) items_sent++;
  endtask

  task automatic issue(logic [1:0] op, logic [15:0] col, logic [31:0] val);
    send_request(op, col, val);
    apply_request(op, col, val);
    foreach (merged_row[k]) pending_results.push_back(merged_row[k]);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 3))
      0:       return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
      1:       return $urandom_range(0, 1) ? ValueMax : ValueMin;
      default: return $urandom();
    endcase
  endfunction

  // strictly increasing columns starting at base, cut short at the top
  function automatic column_q_t rising_columns(int n, int base, int step_max);
    column_q_t q;
    int        c;
    c = base;
    for (int k = 0; k < n; k++) begin
      if (c > 65535) break;
      q.push_back(c[15:0]);
      c += $urandom_range(1, step_max);
    end
    return q;
  endfunction

  // one row: x and y loads interleaved at random, then end of row;
  // a noisy row shuffles its columns and mixes in unused opcodes
  task automatic send_row(int n_x, int n_y, bit narrow, bit noisy);
    column_q_t   xc;
    column_q_t   yc;
    int          base;
    int          step_max;
    int          xi;
    int          yi;
    int          a;
    int          b;
    logic [15:0] tmp;
    step_max = narrow ? 3 : 12000;
    base = narrow ? $urandom_range(0, 65535 - 4 * (n_x + n_y + 1))
                  : $urandom_range(0, 65535);
    xc = rising_columns(n_x, base, step_max);
    if (!narrow) base = $urandom_range(0, 65535);
    yc = rising_columns(n_y, base, step_max);
    if (noisy) begin
      for (int k = 0; k < 4 && xc.size() > 1; k++) begin
        a = $urandom_range(0, xc.size() - 1);
        b = $urandom_range(0, xc.size() - 1);
        tmp = xc[a]; xc[a] = xc[b]; xc[b] = tmp;
      end
      for (int k = 0; k < 4 && yc.size() > 1; k++) begin
        a = $urandom_range(0, yc.size() - 1);
        b = $urandom_range(0, yc.size() - 1);
        tmp = yc[a]; yc[a] = yc[b]; yc[b] = tmp;
      end
    end
    xi = 0;
    yi = 0;
    while (xi < xc.size() || yi < yc.size()) begin
      if (noisy && $urandom_range(0, 3) == 0)
        issue(OpUnused, 16'($urandom()), $urandom());
      if (yi >= yc.size() || (xi < xc.size() && $urandom_range(0, 1))) begin
        issue(OP_LOAD_X, xc[xi], random_value());
        xi++;
      end else begin
        issue(OP_LOAD_Y, yc[yi], random_value());
        yi++;
      end
    end
    issue(OP_END_ROW, 16'($urandom()), $urandom());
  endtask

  // scale writes only once every result of the phase is out
  task automatic write_scale(logic [31:0] a);
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    scale_a = a;
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    row_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: column %0d value %0d",
               m_axis_tdata_o[15:0], $signed(m_axis_tdata_o[47:16]));
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_column", longint'(want.column), longint'(m_axis_tdata_o[15:0]));
        check_field("out_value", longint'($signed(want.value)),
                    longint'($signed(m_axis_tdata_o[47:16])));
        check_field("last", longint'(want.last), longint'(m_axis_tlast_o));
        check_field("row_empty", longint'(want.empty), longint'(m_axis_tuser_o[0]));
        check_field("overflow", longint'(want.overflow), longint'(m_axis_tuser_o[1]));
        check_field("saturated", longint'(want.saturated), longint'(m_axis_tuser_o[2]));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  logic [31:0] phase_scale [NumPhases] = '{32'h0000_0000, 32'h7FFF_FFFF,
                                           32'h8000_0000, 32'h0000_8000,
                                           32'hFFFF_0000, 32'h0003_4000,
                                           32'hFFFF_C000, 32'h0001_0000};

  initial begin
    int phase_start;

    x_count      = 0;
    y_count      = 0;
    row_overflow = 1'b0;
    scale_a      = ScaleReset;

    // reset empty row, extremes, saturation both ways, unused opcode,
    // a mixed row and an unsorted one, all at the reset scale of 1.0
    directed_reqs.push_back(directed_req_t'{OP_END_ROW, 16'h0, 32'h0, 1'b1, EmptyRow});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_X, 16'h0, 32'h7FFF_FFFF, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_END_ROW, 16'h0, 32'h0, 1'b1,
                            row_result_t'{16'h0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_X, 16'hFFFF, 32'h8000_0000, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_Y, 16'hFFFF, 32'h8000_0000, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_END_ROW, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                            row_result_t'{16'hFFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1}});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_X, 16'h1, 32'h0001_0000, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_Y, 16'h1, 32'h7FFF_FFFF, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_END_ROW, 16'h0, 32'h0, 1'b1,
                            row_result_t'{16'h1, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1}});
    directed_reqs.push_back(directed_req_t'{OpUnused, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_END_ROW, 16'h0, 32'h0, 1'b1, EmptyRow});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_X, 16'd3, 32'h0001_8000, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_Y, 16'd2, 32'hFFFF_FFFF, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_X, 16'd7, 32'hFFFF_0000, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_Y, 16'd7, 32'h0002_0000, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_Y, 16'd9, 32'h1234_5678, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_END_ROW, 16'h0, 32'h0, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_X, 16'd10, 32'h0000_0001, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_X, 16'd4, 32'hFFFF_FFFF, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_LOAD_Y, 16'd6, 32'h0000_8000, 1'b0, NoResult});
    directed_reqs.push_back(directed_req_t'{OP_END_ROW, 16'h0, 32'h0, 1'b0, NoResult});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_reqs[n]) begin
      if (directed_reqs[n].typed) begin
        send_request(directed_reqs[n].op, directed_reqs[n].column, directed_reqs[n].value);
        apply_request(directed_reqs[n].op, directed_reqs[n].column, directed_reqs[n].value);
        pending_results.push_back(directed_reqs[n].want);
      end else begin
        issue(directed_reqs[n].op, directed_reqs[n].column, directed_reqs[n].value);
      end
    end

    // random phases: new scale each time, idle pattern cycles through four modes
    for (int p = 0; p < NumPhases; p++) begin
      write_scale(phase_scale[p]);
      case (p % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 81; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 81; end
        default: begin src_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      // full buffers: one row overflows x, a later one overflows y
      if (p == 2) send_row(33, 1, 1'b1, 1'b0);
      if (p == 5) send_row(1, 33, 1'b1, 1'b0);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        send_row($urandom_range(0, 4), $urandom_range(0, 4), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 7) == 0);
      end
    end

    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[sparse_row_scaled_merge_add] OK");
    end else begin
      $display("[sparse_row_scaled_merge_add] ERROR");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("[sparse_row_scaled_merge_add] ERROR");
    $finish;
  end

endmodule

// ----- sparse_row_scaled_merge_add.f -----
design/srsma_pkg.sv
design/srsma_store.sv
design/sparse_row_scaled_merge_add.sv
sim/tb.sv
